/* hdl/batch_sequence_checker_top_assert.svh */
// assertion macros for the batch sequence checker
`ifndef BATCH_SEQUENCE_CHECKER_TOP_ASSERT_SVH
`define BATCH_SEQUENCE_CHECKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSC_ASSERT_IMPL(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define BSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BSC_ASSERT_IMPL(label, expr)
`define BSC_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* hdl/bsc_pkg.sv */
package bsc_pkg;
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_BAD_ENV  = 3'd1;
  localparam logic [2:0] VERDICT_BAD_HDR  = 3'd2;
  localparam logic [2:0] VERDICT_HELD     = 3'd3;
  localparam logic [2:0] VERDICT_DUP      = 3'd4;
  localparam logic [2:0] VERDICT_GAP_REJ  = 3'd5;

  localparam int IN_BITS  = 2 + 1 + 1 + 64 * 3 + 17 + 32 + 32;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OUT_BITS = 3 + 6 + 64 * 2;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  typedef struct packed {
    logic [31:0] sender_lost_samples;
    logic [31:0] sender_lost_batches;
    logic [16:0] samples_in_batch;
    logic [63:0] first_sample_seq;
    logic [63:0] batch_seq;
    logic [63:0] session_tag;
    logic        header_ok;
    logic        envelope_ok;
    logic [1:0]  source_number;
  } in_word_t;

  typedef struct packed {
    logic [63:0] missing_sample_count;
    logic [63:0] missing_batch_count;
    logic        sender_gap_seen;
    logic        sample_out_of_order;
    logic        sample_gap_seen;
    logic        batch_out_of_order;
    logic        batch_gap_seen;
    logic        session_restarted;
    logic [2:0]  verdict;
  } out_word_t;
endpackage

/* hdl/batch_sequence_checker_top.sv */
// One word is taken at a time: s_tready is high only while idle, so a new word
// waits until the last one has left the output handshake. The history scan over
// fill = history entries of that source (up to HISTORY_DEPTH) goes through the
// single RAM read port and a shared 64-bit subtractor. Bad envelope/header words
// skip the scan and compare states. Output is registered.
// rst (synchronous) clears sessions, fill counts and gap-reject; fill bounds RAM reads.
module batch_sequence_checker_top #(
  parameter int SOURCES = 4,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // source_number, envelope_ok, header_ok, session_tag, batch_seq,
  // first_sample_seq, samples_in_batch, sender_lost_batches, sender_lost_samples
  input  logic [bsc_pkg::IN_BYTES*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // verdict, session_restarted, batch_gap_seen, batch_out_of_order,
  // sample_gap_seen, sample_out_of_order, sender_gap_seen,
  // missing_batch_count, missing_sample_count
  output logic [bsc_pkg::OUT_BYTES*8-1:0] m_tdata
);
  import bsc_pkg::*;
  `include "batch_sequence_checker_top_assert.svh"

  localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int AW = $clog2(SOURCES * HISTORY_DEPTH) > 0 ?
                      $clog2(SOURCES * HISTORY_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SESS = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CMPB = 3'd3;
  localparam logic [2:0] ST_CMPS = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state;
  logic reject_on_gap;
  in_word_t item;
  out_word_t res;
  logic [SW-1:0] src;

  logic [SOURCES-1:0] session_known, high_water_known, held;
  logic [63:0] current_session [SOURCES];
  logic [63:0] high_water_batch [SOURCES];
  logic [63:0] next_expected [SOURCES];
  logic [FW-1:0] fill [SOURCES];
  logic [HW-1:0] oldest [SOURCES];

  logic [FW-1:0] idx;
  logic rd_pend, dup;
  logic has_gap;

  // shared comparator/subtractor
  logic [63:0] cmp_a, cmp_b;
  logic [64:0] diff;
  assign diff = {1'b0, cmp_a} - {1'b0, cmp_b};

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_rdata;
  logic [HW-1:0] slot_rd, slot_wr;

  always_comb begin
    logic [HW:0] t;
    t = {1'b0, oldest[src]} + idx[HW:0];
    if (t >= (HW+1)'(HISTORY_DEPTH)) begin
      t = t - (HW+1)'(HISTORY_DEPTH);
    end
    slot_rd = t[HW-1:0];
    t = {1'b0, oldest[src]} + fill[src][HW:0];
    if (fill[src] == FW'(HISTORY_DEPTH)) begin
      t = {1'b0, oldest[src]};
    end else if (t >= (HW+1)'(HISTORY_DEPTH)) begin
      t = t - (HW+1)'(HISTORY_DEPTH);
    end
    slot_wr = t[HW-1:0];
  end

  assign ram_raddr = AW'(src) * AW'(HISTORY_DEPTH) + AW'(slot_rd);
  assign ram_waddr = AW'(src) * AW'(HISTORY_DEPTH) + AW'(slot_wr);

  bsc_ram #(.WIDTH(64), .DEPTH(SOURCES * HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.batch_seq),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    cmp_a = ram_rdata;
    cmp_b = item.batch_seq;
    unique case (state)
      ST_CMPB: begin
        cmp_a = item.batch_seq;
        cmp_b = high_water_batch[src];
      end
      ST_CMPS: begin
        cmp_a = item.first_sample_seq;
        cmp_b = next_expected[src];
      end
      default: begin
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = (OUT_BYTES*8)'(res);
  assign ram_we = (state == ST_DONE) && !(has_gap && reject_on_gap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      reject_on_gap <= 1'b0;
      src <= '0;
      session_known <= '0;
      high_water_known <= '0;
      held <= '0;
      for (int i = 0; i < SOURCES; i++) begin
        fill[i] <= '0;
        oldest[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        reject_on_gap <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            item <= in_word_t'(s_tdata[IN_BITS-1:0]);
            src <= SW'(s_tdata[1:0]);
            res <= '0;
            has_gap <= 1'b0;
            idx <= '0;
            rd_pend <= 1'b0;
            dup <= 1'b0;
            state <= ST_SESS;
          end
        end
        ST_SESS: begin
          if (32'(item.source_number) >= SOURCES || !item.envelope_ok) begin
            res.verdict <= VERDICT_BAD_ENV;
            state <= ST_OUT;
          end else if (!item.header_ok) begin
            res.verdict <= VERDICT_BAD_HDR;
            state <= ST_OUT;
          end else begin
            if (!session_known[src] || current_session[src] != item.session_tag) begin
              res.session_restarted <= session_known[src];
              session_known[src] <= 1'b1;
              current_session[src] <= item.session_tag;
              high_water_known[src] <= 1'b0;
              held[src] <= 1'b0;
              fill[src] <= '0;
              oldest[src] <= '0;
              state <= ST_CMPB;
            end else if (held[src]) begin
              res.verdict <= VERDICT_HELD;
              state <= ST_OUT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // one read issued per cycle, compared in the cycle after
          if (rd_pend && diff[63:0] == '0) begin
            dup <= 1'b1;
          end
          if (dup || (rd_pend && diff[63:0] == '0)) begin
            res.verdict <= VERDICT_DUP;
            state <= ST_OUT;
          end else if (idx < fill[src]) begin
            idx <= idx + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= ST_CMPB;
          end
        end
        ST_CMPB: begin
          if (high_water_known[src]) begin
            if (high_water_batch[src] != '1 && !diff[64] && diff[63:0] > 64'd1) begin
              res.batch_gap_seen <= 1'b1;
              res.missing_batch_count <= diff[63:0] - 64'd1;
              has_gap <= 1'b1;
            end else if (diff[64]) begin
              res.batch_out_of_order <= 1'b1;
            end
          end
          state <= ST_CMPS;
        end
        ST_CMPS: begin
          if (high_water_known[src]) begin
            if (!diff[64] && diff[63:0] != '0) begin
              res.sample_gap_seen <= 1'b1;
              res.missing_sample_count <= diff[63:0];
              has_gap <= 1'b1;
            end else if (diff[64]) begin
              res.sample_out_of_order <= 1'b1;
            end
          end
          if (item.sender_lost_batches != '0 || item.sender_lost_samples != '0) begin
            res.sender_gap_seen <= 1'b1;
            has_gap <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (has_gap && reject_on_gap) begin
            held[src] <= 1'b1;
            res.verdict <= VERDICT_GAP_REJ;
          end else begin
            res.verdict <= VERDICT_ACCEPT;
            if (fill[src] < FW'(HISTORY_DEPTH)) begin
              fill[src] <= fill[src] + 1'b1;
            end else if (oldest[src] == HW'(HISTORY_DEPTH - 1)) begin
              oldest[src] <= '0;
            end else begin
              oldest[src] <= oldest[src] + 1'b1;
            end
            if (!high_water_known[src] || item.batch_seq > high_water_batch[src]) begin
              high_water_known[src] <= 1'b1;
              high_water_batch[src] <= item.batch_seq;
              next_expected[src] <= item.first_sample_seq + 64'(item.samples_in_batch);
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BSC_ASSERT_IMPL(a_fill_bound, fill[src] <= FW'(HISTORY_DEPTH))
  `BSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BSC_ASSERT_NEXT(a_done_out, state == ST_DONE, state == ST_OUT)
endmodule

/* hdl/bsc_ram.sv */
module bsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
